@@ rtl/hsfe_pkg.sv @@
`default_nettype none

package hsfe_pkg;

   // field widths
   localparam int FRAC_BITS_DEF = 16;
   localparam int IN_W          = 18;
   localparam int OUT_W         = 18;
   localparam int TAG_W         = 7;
   localparam int NODE_W        = 5;
   localparam int OUT_MAX       = 131071;
   localparam int OUT_MIN       = -131072;

   // stream word layouts
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 88;

   // last node number per element kind
   localparam logic [NODE_W-1:0] LAST_LIN  = NODE_W'(7);
   localparam logic [NODE_W-1:0] LAST_QUAD = NODE_W'(19);

   // node_mode codes
   localparam logic MODE_LIN  = 1'b0;
   localparam logic MODE_QUAD = 1'b1;

   // extra right shift beyond FRAC_BITS applied when rounding a product
   typedef enum logic [1:0] {
      SH_0 = 2'd0,
      SH_1 = 2'd1,
      SH_2 = 2'd2,
      SH_3 = 2'd3
   } shift_type;

   // axis of a mid-edge node (0 = r, 1 = s, 2 = t)
   function automatic logic [1:0] edge_axis(input logic [3:0] e);
      logic [1:0] a;
      unique case (e)
         4'd0, 4'd2, 4'd4, 4'd6: a = 2'd0;
         4'd1, 4'd3, 4'd5, 4'd7: a = 2'd1;
         default:                a = 2'd2;
      endcase
      return a;
   endfunction

   // positive-sign bits {t,s,r} of a mid-edge node (axis bit unused)
   function automatic logic [2:0] edge_pos(input logic [3:0] e);
      logic [2:0] p;
      unique case (e)
         4'd1:    p = 3'b001;
         4'd2:    p = 3'b010;
         4'd4:    p = 3'b100;
         4'd5:    p = 3'b101;
         4'd6:    p = 3'b110;
         4'd7:    p = 3'b100;
         4'd9:    p = 3'b001;
         4'd10:   p = 3'b011;
         4'd11:   p = 3'b010;
         default: p = 3'b000;
      endcase
      return p;
   endfunction

   // positive-sign bits {t,s,r} of a corner node
   function automatic logic [2:0] corner_pos(input logic [2:0] n);
      return {n[2], n[1], n[0] ^ n[1]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/hsfe_front.sv @@
`default_nettype none

module hsfe_front #(
   parameter int FRAC_BITS = hsfe_pkg::FRAC_BITS_DEF,
   parameter int VW        = FRAC_BITS + 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // coord_r[17:0], coord_s[35:18], coord_t[53:36], point_index[60:54], zero fill
   input  wire logic [hsfe_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                             node_mode,
   input  wire logic                             pop,
   output logic                                  head_valid,
   output logic signed [VW-1:0]                  x_r,
   output logic signed [VW-1:0]                  x_s,
   output logic signed [VW-1:0]                  x_t,
   output logic signed [VW-1:0]                  q_r,
   output logic signed [VW-1:0]                  q_s,
   output logic signed [VW-1:0]                  q_t,
   output logic [hsfe_pkg::TAG_W-1:0]            head_tag,
   output logic                                  head_mode
);
   import hsfe_pkg::*;

   localparam int CW = (VW > IN_W + 1) ? VW : IN_W + 1;
   localparam int PW = 2 * VW;
   localparam int EW = 6 * VW + TAG_W + 1;
   localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;
   localparam logic signed [VW-1:0] ONE   = VW'(1) <<< FRAC_BITS;
   localparam logic [PW-1:0]        HALF  = PW'(1) << (FRAC_BITS - 1);

   logic signed [IN_W-1:0] raw [3];
   logic signed [VW-1:0]   xc  [3];
   logic signed [VW-1:0]   qc  [3];
   logic [EW-1:0]          ent_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   push;
   logic [EW-1:0]          head;

   assign raw[0] = req_tdata[IN_W-1:0];
   assign raw[1] = req_tdata[2*IN_W-1:IN_W];
   assign raw[2] = req_tdata[3*IN_W-1:2*IN_W];

   // clamp to [-one, one] and form 1 - x*x per axis
   always_comb begin
      logic signed [CW-1:0] xe;
      logic [PW-1:0]        sq;
      for (int k = 0; k < 3; k++) begin
         xe = CW'(raw[k]);
         if (xe > ONE_C)       xe = ONE_C;
         else if (xe < -ONE_C) xe = -ONE_C;
         xc[k] = VW'(xe);
         sq    = PW'(xc[k] * xc[k]);
         qc[k] = ONE - VW'((sq + HALF) >> FRAC_BITS);
      end
   end

   // two-word queue toward the back end
   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (cnt_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= {node_mode, req_tdata[3*IN_W+TAG_W-1:3*IN_W],
                               qc[2], qc[1], qc[0], xc[2], xc[1], xc[0]};
      end
   end

   assign head      = ent_ff[rd_ptr_ff];
   assign x_r       = head[VW-1:0];
   assign x_s       = head[2*VW-1:VW];
   assign x_t       = head[3*VW-1:2*VW];
   assign q_r       = head[4*VW-1:3*VW];
   assign q_s       = head[5*VW-1:4*VW];
   assign q_t       = head[6*VW-1:5*VW];
   assign head_tag  = head[6*VW+TAG_W-1:6*VW];
   assign head_mode = head[EW-1];

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");

endmodule

`default_nettype wire

@@ rtl/hsfe_back.sv @@
`default_nettype none

module hsfe_back #(
   parameter int FRAC_BITS = hsfe_pkg::FRAC_BITS_DEF,
   parameter int VW        = FRAC_BITS + 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             head_valid,
   input  wire logic signed [VW-1:0]             x_r,
   input  wire logic signed [VW-1:0]             x_s,
   input  wire logic signed [VW-1:0]             x_t,
   input  wire logic signed [VW-1:0]             q_r,
   input  wire logic signed [VW-1:0]             q_s,
   input  wire logic signed [VW-1:0]             q_t,
   input  wire logic [hsfe_pkg::TAG_W-1:0]       head_tag,
   input  wire logic                             head_mode,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tlast,
   // node_index[4:0], shape_value[22:5], deriv_r[40:23], deriv_s[58:41],
   // deriv_t[76:59], point_tag[83:77], zero fill
   output logic [hsfe_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import hsfe_pkg::*;

   localparam int PW = 2 * VW;
   localparam int SW = (VW > OUT_W) ? VW : OUT_W;
   localparam logic signed [VW-1:0] ONE    = VW'(1) <<< FRAC_BITS;
   localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } meta_type;

   // round(p / 2^(FRAC_BITS+k)), ties away from zero
   function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p,
                                                input shift_type k);
      logic [PW-1:0] mag;
      logic [PW-1:0] r;
      mag = p[PW-1] ? PW'(-p) : PW'(p);
      unique case (k)
         SH_0: r = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         SH_1: r = (mag + (PW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
         SH_2: r = (mag + (PW'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
         default: r = (mag + (PW'(1) << (FRAC_BITS + 2))) >> (FRAC_BITS + 3);
      endcase
      return p[PW-1] ? -VW'(r) : VW'(r);
   endfunction

   logic                 adv;
   logic [NODE_W-1:0]    node_cnt_ff, node_cnt_in;
   logic [NODE_W-1:0]    last_node;
   logic                 issue;
   logic signed [VW-1:0] xv [3];
   logic signed [VW-1:0] qv [3];

   // operand selection results, per lane (shape value, d/dr, d/ds, d/dt)
   logic signed [VW-1:0] op_a [4], op_b [4], op_c [4], op_d [4];
   shift_type            k1 [4], k2 [4], k3 [4];
   logic                 ngv [4];

   // stage registers
   logic signed [VW-1:0] a0_ff [4], b0_ff [4], c0_ff [4], d0_ff [4];
   shift_type            k10_ff [4], k20_ff [4], k30_ff [4];
   logic                 ng0_ff [4];
   logic signed [VW-1:0] m1_ff [4], c1_ff [4], d1_ff [4];
   shift_type            k21_ff [4], k31_ff [4];
   logic                 ng1_ff [4];
   logic signed [VW-1:0] m2_ff [4], d2_ff [4];
   shift_type            k32_ff [4];
   logic                 ng2_ff [4];
   logic signed [VW-1:0] m3_ff [4];
   logic                 ng3_ff [4];
   meta_type             mt0_ff, mt1_ff, mt2_ff, mt3_ff, meta_in;
   logic [OUT_W-1:0]     res_ff [4];
   logic [OUT_W-1:0]     res_in [4];
   meta_type             out_ff;

   assign xv[0] = x_r;
   assign xv[1] = x_s;
   assign xv[2] = x_t;
   assign qv[0] = q_r;
   assign qv[1] = q_s;
   assign qv[2] = q_t;

   // whole pipeline moves when the output word is free or being taken
   assign adv       = !out_ff.valid || rsp_tready;
   assign last_node = (head_mode == MODE_QUAD) ? LAST_QUAD : LAST_LIN;
   assign issue     = head_valid && adv;
   assign pop       = issue && (node_cnt_ff == last_node);

   // node sequencer
   always_comb begin
      node_cnt_in = node_cnt_ff;
      if (issue) node_cnt_in = pop ? '0 : node_cnt_ff + NODE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) node_cnt_ff <= '0;
      else       node_cnt_ff <= node_cnt_in;
   end

   // operand selection for the current node
   always_comb begin
      logic [2:0]           cpos, epos;
      logic [3:0]           e;
      logic [1:0]           ax, ab, ac;
      logic signed [VW-1:0] pc [3], pe [3], sx [3];
      logic signed [VW-1:0] lsum;
      cpos = corner_pos(node_cnt_ff[2:0]);
      e    = 4'(node_cnt_ff - NODE_W'(8));
      epos = edge_pos(e);
      ax   = edge_axis(e);
      ab   = (ax == 2'd0) ? 2'd1 : 2'd0;
      ac   = (ax == 2'd2) ? 2'd1 : 2'd2;
      for (int k = 0; k < 3; k++) begin
         pc[k] = cpos[k] ? ONE + xv[k] : ONE - xv[k];
         sx[k] = cpos[k] ? xv[k] : -xv[k];
         pe[k] = epos[k] ? ONE + xv[k] : ONE - xv[k];
      end
      lsum = sx[0] + sx[1] + sx[2] - (ONE <<< 1);
      for (int j = 0; j < 4; j++) begin
         op_a[j] = ONE; op_b[j] = ONE; op_c[j] = ONE; op_d[j] = ONE;
         k1[j] = SH_0; k2[j] = SH_0; k3[j] = SH_0; ngv[j] = 1'b0;
      end
      if (head_mode == MODE_LIN) begin
         op_a[0] = pc[0]; op_b[0] = pc[1]; op_c[0] = pc[2]; k2[0] = SH_3;
         for (int k = 0; k < 3; k++) begin
            op_a[k+1] = pc[(k+1)%3];
            op_b[k+1] = pc[(k+2)%3];
            k1[k+1]   = SH_3;
            ngv[k+1]  = !cpos[k];
         end
      end else if (node_cnt_ff[4:3] == 2'b00) begin
         // serendipity corner
         op_a[0] = pc[0]; op_b[0] = pc[1]; op_c[0] = pc[2]; op_d[0] = lsum;
         k3[0] = SH_3;
         for (int k = 0; k < 3; k++) begin
            op_a[k+1] = pc[(k+1)%3];
            op_b[k+1] = pc[(k+2)%3];
            op_c[k+1] = lsum + sx[k] + ONE;
            k2[k+1]   = SH_3;
            ngv[k+1]  = !cpos[k];
         end
      end else begin
         // mid-edge node
         op_a[0] = qv[ax]; op_b[0] = pe[ab]; op_c[0] = pe[ac]; k2[0] = SH_2;
         for (int k = 0; k < 3; k++) begin
            if (ax == 2'(k)) begin
               op_a[k+1] = xv[ax]; op_b[k+1] = pe[ab]; op_c[k+1] = pe[ac];
               k2[k+1] = SH_1; ngv[k+1] = 1'b1;
            end else if (ab == 2'(k)) begin
               op_a[k+1] = qv[ax]; op_b[k+1] = pe[ac];
               k1[k+1] = SH_2; ngv[k+1] = !epos[k];
            end else begin
               op_a[k+1] = qv[ax]; op_b[k+1] = pe[ab];
               k1[k+1] = SH_2; ngv[k+1] = !epos[k];
            end
         end
      end
      meta_in.valid = issue;
      meta_in.node  = node_cnt_ff;
      meta_in.tag   = head_tag;
      meta_in.last  = (node_cnt_ff == last_node);
   end

   // saturate final products
   always_comb begin
      logic signed [SW-1:0] v;
      for (int j = 0; j < 4; j++) begin
         v = ng3_ff[j] ? -SW'(m3_ff[j]) : SW'(m3_ff[j]);
         if (v > SAT_HI)      v = SAT_HI;
         else if (v < SAT_LO) v = SAT_LO;
         res_in[j] = OUT_W'(v);
      end
   end

   // control: node tags and valid flags through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         mt0_ff.valid <= 1'b0;
         mt1_ff.valid <= 1'b0;
         mt2_ff.valid <= 1'b0;
         mt3_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         mt0_ff <= meta_in;
         mt1_ff <= mt0_ff;
         mt2_ff <= mt1_ff;
         mt3_ff <= mt2_ff;
         out_ff <= mt3_ff;
      end
   end

   // datapath: three multiply stages and the output word
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            a0_ff[j]  <= op_a[j];
            b0_ff[j]  <= op_b[j];
            c0_ff[j]  <= op_c[j];
            d0_ff[j]  <= op_d[j];
            k10_ff[j] <= k1[j];
            k20_ff[j] <= k2[j];
            k30_ff[j] <= k3[j];
            ng0_ff[j] <= ngv[j];
            m1_ff[j]  <= rnd(PW'(a0_ff[j] * b0_ff[j]), k10_ff[j]);
            c1_ff[j]  <= c0_ff[j];
            d1_ff[j]  <= d0_ff[j];
            k21_ff[j] <= k20_ff[j];
            k31_ff[j] <= k30_ff[j];
            ng1_ff[j] <= ng0_ff[j];
            m2_ff[j]  <= rnd(PW'(m1_ff[j] * c1_ff[j]), k21_ff[j]);
            d2_ff[j]  <= d1_ff[j];
            k32_ff[j] <= k31_ff[j];
            ng2_ff[j] <= ng1_ff[j];
            m3_ff[j]  <= rnd(PW'(m2_ff[j] * d2_ff[j]), k32_ff[j]);
            ng3_ff[j] <= ng2_ff[j];
            res_ff[j] <= res_in[j];
         end
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.tag, res_ff[3], res_ff[2], res_ff[1],
                                    res_ff[0], out_ff.node});

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      node_cnt_ff <= LAST_QUAD) else $error("node counter out of range");
   a_last_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (out_ff.node == LAST_LIN || out_ff.node == LAST_QUAD))
      else $error("last flag on a non-final node");
   a_first_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> node_cnt_ff == '0) else $error("counter not restarted after pop");

endmodule

`default_nettype wire

@@ rtl/hexa_shape_function_eval.sv @@
// Hexahedral shape function evaluator, 8-node or 20-node per csr_data.
// Each node result passes through the stage 0 operand registers, the three multiply stages and the output word.
// Throughput: one node result per cycle while rsp_tready does not stall the pipeline, 8 or 20 node results per point;
// the node sequencer in the back end sets this, the front queues two points.
// Reset: synchronous, active high; clears queue, pipeline and node_mode.
`default_nettype none

module hexa_shape_function_eval #(
   parameter int FRAC_BITS = hsfe_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // coord_r[17:0], coord_s[35:18], coord_t[53:36], point_index[60:54], zero fill
   input  wire logic [hsfe_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tlast,
   // node_index[4:0], shape_value[22:5], deriv_r[40:23], deriv_s[58:41],
   // deriv_t[76:59], point_tag[83:77], zero fill
   output logic [hsfe_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic                             csr_data
);
   import hsfe_pkg::*;

   localparam int VW = FRAC_BITS + 5;

   logic                 mode_ff, mode_in;
   logic                 head_valid, head_mode, pop;
   logic signed [VW-1:0] x_r, x_s, x_t, q_r, q_s, q_t;
   logic [TAG_W-1:0]     head_tag;

   // node_mode register
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_LIN;
      else       mode_ff <= mode_in;
   end

   hsfe_front #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .node_mode  (mode_ff),
      .pop        (pop),
      .head_valid (head_valid),
      .x_r        (x_r),
      .x_s        (x_s),
      .x_t        (x_t),
      .q_r        (q_r),
      .q_s        (q_s),
      .q_t        (q_t),
      .head_tag   (head_tag),
      .head_mode  (head_mode)
   );

   hsfe_back #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .x_r        (x_r),
      .x_s        (x_s),
      .x_t        (x_t),
      .q_r        (q_r),
      .q_s        (q_s),
      .q_t        (q_t),
      .head_tag   (head_tag),
      .head_mode  (head_mode),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
